// File: rtl/pmgs_pkg.sv
// Shared types, constants and a helper function of the plate model gravity sum block.
package pmgs_pkg;

  localparam int MaxFaces   = 1024;
  localparam int FaceIdxW   = 10;
  localparam int CntW       = 11;
  localparam int CoordW     = 32;
  localparam int FracBits   = 16;
  localparam int UFrac      = 28;
  localparam int DiffW      = CoordW + 1;
  localparam int NormW      = UFrac;
  localparam int R2W        = 58;
  localparam int SqW        = 60;
  localparam int RnW        = 30;
  localparam int DivW       = 62;
  localparam int UW         = 30;
  localparam int MulBW      = 35;
  localparam int ProdW      = 64;
  localparam int AccW       = 64;
  localparam int WW         = 35;
  localparam int ProjW      = ProdW - UFrac;
  localparam int VW         = ProjW + 1;
  localparam int ShW        = 6;
  localparam int FaceW      = 6 * CoordW;
  localparam int SqrtLast   = 29;
  localparam int DivLast    = DivW - 1;
  localparam int StepW      = 6;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_START,
    OP_READ,
    OP_DIFF,
    OP_NORM,
    OP_SQ,
    OP_SQACC,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_DIVU_INIT,
    OP_DIV_STEP,
    OP_USTORE,
    OP_TN,
    OP_TACC,
    OP_W,
    OP_UW,
    OP_V,
    OP_DIVA_INIT,
    OP_ACCQ,
    OP_NEXT,
    OP_FINISH
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] lane;
  } cmd_t;

  typedef struct packed {
    logic zero_dist;
    logic overflow;
    logic last_face;
    logic cnt_zero;
  } stat_t;

  // Bit 64 of the result is the clip flag, bits 63:0 the clipped sum.
  function automatic logic [AccW:0] add_clip(input logic signed [AccW-1:0] a,
                                             input logic signed [AccW-1:0] b);
    logic signed [AccW:0] s;
    logic signed [AccW:0] lim;
    s   = {a[AccW-1], a} + {b[AccW-1], b};
    lim = {3'b001, {(AccW-2){1'b0}}};
    if (s > lim) begin
      return {1'b1, lim[AccW-1:0]};
    end else if (s < -lim) begin
      return {1'b1, (-lim[AccW-1:0])};
    end
    return {1'b0, s[AccW-1:0]};
  endfunction

endpackage

// File: rtl/plate_model_gravity_sum.sv
// Top level of the plate model gravity sum block.
//
// A transaction is taken at a clock edge with start high and busy low. With
// func_i low it writes the face at face_index_i (center and area normal) into
// the face table in that cycle and produces no result. With func_i high it
// takes the field point and sums the first face_count faces (at most 1024) of
// the table. face_count is written through cfg_we_i and cfg_wdata_i; the user
// must do so only while busy is low, as the block does not enforce it. Each
// face runs through a sequencer and one shared datapath: a 30-step square root
// and up to six 62-step restoring divisions dominate (a face at zero distance
// skips them, and an acceleration term that clips skips its division). After a
// query is taken, busy stays high until the sum is done. The result ports
// hold the result from the first cycle with busy low again, marked by
// result_valid_o for exactly one cycle. The receiver cannot stall the result.
// Reset clears the sequencer, face_count and the result strobe; the face table is
// not cleared, and every face that a query uses must have been loaded first.
module plate_model_gravity_sum (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                cfg_we_i,
  input  logic [pmgs_pkg::CntW-1:0]           cfg_wdata_i,
  input  logic                                func_i,
  input  logic [pmgs_pkg::FaceIdxW-1:0]       face_index_i,
  input  logic signed [pmgs_pkg::CoordW-1:0]  center_x_i,
  input  logic signed [pmgs_pkg::CoordW-1:0]  center_y_i,
  input  logic signed [pmgs_pkg::CoordW-1:0]  center_z_i,
  input  logic signed [pmgs_pkg::CoordW-1:0]  normal_x_i,
  input  logic signed [pmgs_pkg::CoordW-1:0]  normal_y_i,
  input  logic signed [pmgs_pkg::CoordW-1:0]  normal_z_i,
  input  logic signed [pmgs_pkg::CoordW-1:0]  point_x_i,
  input  logic signed [pmgs_pkg::CoordW-1:0]  point_y_i,
  input  logic signed [pmgs_pkg::CoordW-1:0]  point_z_i,
  output logic signed [pmgs_pkg::CoordW-1:0]  potential_o,
  output logic signed [pmgs_pkg::CoordW-1:0]  accel_x_o,
  output logic signed [pmgs_pkg::CoordW-1:0]  accel_y_o,
  output logic signed [pmgs_pkg::CoordW-1:0]  accel_z_o,
  output logic                                saturated_o,
  output logic                                result_valid_o
);
  import pmgs_pkg::*;

  cmd_t             cmd;
  stat_t            stat;
  logic [FaceW-1:0] face;

  assign face = {center_x_i, center_y_i, center_z_i, normal_x_i, normal_y_i, normal_z_i};

  pmgs_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .func_i (func_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  pmgs_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .face_index_i   (face_index_i),
    .face_i         (face),
    .point_x_i      (point_x_i),
    .point_y_i      (point_y_i),
    .point_z_i      (point_z_i),
    .potential_o    (potential_o),
    .accel_x_o      (accel_x_o),
    .accel_y_o      (accel_y_o),
    .accel_z_o      (accel_z_o),
    .saturated_o    (saturated_o),
    .result_valid_o (result_valid_o)
  );

endmodule

// File: rtl/pmgs_ctrl.sv
// Sequencer that steps the face datapath through each query.
module pmgs_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  logic           func_i,
  input  pmgs_pkg::stat_t stat_i,
  output pmgs_pkg::cmd_t  cmd_o,
  output logic           busy
);
  import pmgs_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_READ, S_DIFF, S_NORM, S_SQ, S_SQACC, S_SQRT_INIT, S_SQRT,
    S_DIVU_INIT, S_DIVU, S_USTORE, S_TN, S_TACC, S_W, S_UW, S_V,
    S_DIVA_INIT, S_DIVA, S_ACCQ, S_NEXT, S_FINISH
  } state_e;

  state_e           state_q, state_d;
  logic [1:0]       lane_q, lane_d;
  logic [StepW-1:0] step_q, step_d;

  assign busy = (state_q != S_IDLE);

  always_comb begin
    state_d    = state_q;
    lane_d     = lane_q;
    step_d     = step_q;
    cmd_o.op   = OP_NONE;
    cmd_o.lane = lane_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          if (!func_i) begin
            cmd_o.op = OP_LOAD;
          end else begin
            cmd_o.op = OP_START;
            state_d  = stat_i.cnt_zero ? S_FINISH : S_READ;
          end
        end
      end
      S_READ: begin
        cmd_o.op = OP_READ;
        state_d  = S_DIFF;
      end
      S_DIFF: begin
        cmd_o.op = OP_DIFF;
        state_d  = S_NORM;
      end
      S_NORM: begin
        cmd_o.op = OP_NORM;
        lane_d   = 2'd0;
        state_d  = stat_i.zero_dist ? S_NEXT : S_SQ;
      end
      S_SQ: begin
        cmd_o.op = OP_SQ;
        state_d  = S_SQACC;
      end
      S_SQACC: begin
        cmd_o.op = OP_SQACC;
        if (lane_q == 2'd2) begin
          state_d = S_SQRT_INIT;
        end else begin
          lane_d  = lane_q + 2'd1;
          state_d = S_SQ;
        end
      end
      S_SQRT_INIT: begin
        cmd_o.op = OP_SQRT_INIT;
        step_d   = '0;
        state_d  = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.op = OP_SQRT_STEP;
        step_d   = step_q + 1'b1;
        if (step_q == StepW'(SqrtLast)) begin
          lane_d  = 2'd0;
          state_d = S_DIVU_INIT;
        end
      end
      S_DIVU_INIT: begin
        cmd_o.op = OP_DIVU_INIT;
        step_d   = '0;
        state_d  = S_DIVU;
      end
      S_DIVU: begin
        cmd_o.op = OP_DIV_STEP;
        step_d   = step_q + 1'b1;
        if (step_q == StepW'(DivLast)) begin
          state_d = S_USTORE;
        end
      end
      S_USTORE: begin
        cmd_o.op = OP_USTORE;
        if (lane_q == 2'd2) begin
          lane_d  = 2'd0;
          state_d = S_TN;
        end else begin
          lane_d  = lane_q + 2'd1;
          state_d = S_DIVU_INIT;
        end
      end
      S_TN: begin
        cmd_o.op = OP_TN;
        state_d  = S_TACC;
      end
      S_TACC: begin
        cmd_o.op = OP_TACC;
        if (lane_q == 2'd2) begin
          state_d = S_W;
        end else begin
          lane_d  = lane_q + 2'd1;
          state_d = S_TN;
        end
      end
      S_W: begin
        cmd_o.op = OP_W;
        lane_d   = 2'd0;
        state_d  = S_UW;
      end
      S_UW: begin
        cmd_o.op = OP_UW;
        state_d  = S_V;
      end
      S_V: begin
        cmd_o.op = OP_V;
        state_d  = stat_i.overflow ? S_ACCQ : S_DIVA_INIT;
      end
      S_DIVA_INIT: begin
        cmd_o.op = OP_DIVA_INIT;
        step_d   = '0;
        state_d  = S_DIVA;
      end
      S_DIVA: begin
        cmd_o.op = OP_DIV_STEP;
        step_d   = step_q + 1'b1;
        if (step_q == StepW'(DivLast)) begin
          state_d = S_ACCQ;
        end
      end
      S_ACCQ: begin
        cmd_o.op = OP_ACCQ;
        if (lane_q == 2'd2) begin
          state_d = S_NEXT;
        end else begin
          lane_d  = lane_q + 2'd1;
          state_d = S_UW;
        end
      end
      S_NEXT: begin
        cmd_o.op = OP_NEXT;
        state_d  = stat_i.last_face ? S_FINISH : S_READ;
      end
      S_FINISH: begin
        cmd_o.op = OP_FINISH;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      lane_q  <= 2'd0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      lane_q  <= lane_d;
      step_q  <= step_d;
    end
  end

endmodule

// File: rtl/pmgs_dpath.sv
// Face table, shared multiplier, square root and divider units, and accumulators.
module pmgs_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pmgs_pkg::cmd_t                      cmd_i,
  output pmgs_pkg::stat_t                     stat_o,
  input  logic                                cfg_we_i,
  input  logic [pmgs_pkg::CntW-1:0]           cfg_wdata_i,
  input  logic [pmgs_pkg::FaceIdxW-1:0]       face_index_i,
  input  logic [pmgs_pkg::FaceW-1:0]          face_i,
  input  logic signed [pmgs_pkg::CoordW-1:0]  point_x_i,
  input  logic signed [pmgs_pkg::CoordW-1:0]  point_y_i,
  input  logic signed [pmgs_pkg::CoordW-1:0]  point_z_i,
  output logic signed [pmgs_pkg::CoordW-1:0]  potential_o,
  output logic signed [pmgs_pkg::CoordW-1:0]  accel_x_o,
  output logic signed [pmgs_pkg::CoordW-1:0]  accel_y_o,
  output logic signed [pmgs_pkg::CoordW-1:0]  accel_z_o,
  output logic                                saturated_o,
  output logic                                result_valid_o
);
  import pmgs_pkg::*;

  logic [FaceW-1:0]              face_mem [MaxFaces];
  logic [FaceW-1:0]              rdata_q;
  logic [CntW-1:0]               face_count_q;
  logic [CntW-1:0]               cnt_eff;
  logic [FaceIdxW-1:0]           idx_q;
  logic signed [CoordW-1:0]      point_q [3];
  logic signed [DiffW-1:0]       d_q [3];
  logic signed [CoordW-1:0]      n_q [3];
  logic [NormW-1:0]              a_q [3];
  logic [ShW-1:0]                e_q;
  logic signed [ProdW-1:0]       prod_q;
  logic [R2W-1:0]                r2_q;
  logic [SqW-1:0]                sx_q, sr_q, sb_q;
  logic [DivW-1:0]               num_q, quo_q;
  logic [RnW-1:0]                rem_q;
  logic signed [UW-1:0]          u_q [3];
  logic signed [AccW-1:0]        t_q;
  logic signed [WW-1:0]          w_q;
  logic signed [AccW-1:0]        acc_q [4];
  logic                          flag_q;
  logic [VW-1:0]                 av_q;
  logic                          vneg_q, ovf_q;
  logic signed [CoordW-1:0]      res_q [4];
  logic                          sat_q, valid_q;

  logic [DiffW-1:0]              mag_c [3];
  logic [DiffW-1:0]              m_c;
  logic [ShW:0]                  bl_c;
  logic signed [ShW+1:0]         k_c;
  logic signed [UW-1:0]          ma_c;
  logic signed [MulBW-1:0]       mb_c;
  logic signed [UW+MulBW-1:0]    mul_c;
  logic [SqW-1:0]                rb_c;
  logic [RnW:0]                  trial_c;
  logic signed [ProjW-1:0]       proj_c;
  logic signed [VW-1:0]          v_c;
  logic [VW-1:0]                 av_c;
  logic [ShW:0]                  rsh_c;
  logic                          ovf_c;
  logic [1:0]                    al_c;
  logic [AccW:0]                 sum_c;
  logic signed [AccW-1:0]        term_c;
  logic [DivW-1:0]               qv_c;
  logic [DivW+VW-1:0]            nsh_c;
  logic                          fin_flag_c;
  logic signed [CoordW-1:0]      fin_c [4];
  logic signed [AccW-1:0]        qt;

  assign cnt_eff = (face_count_q > CntW'(MaxFaces)) ? CntW'(MaxFaces) : face_count_q;

  always_comb begin
    m_c  = '0;
    bl_c = '0;
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = d_q[i][DiffW-1] ? DiffW'(-d_q[i]) : DiffW'(d_q[i]);
      if (mag_c[i] > m_c) begin
        m_c = mag_c[i];
      end
    end
    for (int b = 0; b < DiffW; b++) begin
      if (m_c[b]) begin
        bl_c = (ShW+1)'(b + 1);
      end
    end
    k_c = $signed({1'b0, bl_c}) - (ShW+2)'(UFrac);
  end

  always_comb begin
    ma_c = '0;
    mb_c = '0;
    case (cmd_i.op)
      OP_SQ: begin
        ma_c = $signed(UW'(a_q[cmd_i.lane]));
        mb_c = $signed(MulBW'(a_q[cmd_i.lane]));
      end
      OP_TN: begin
        ma_c = u_q[cmd_i.lane];
        mb_c = MulBW'(n_q[cmd_i.lane]);
      end
      OP_UW: begin
        ma_c = u_q[cmd_i.lane];
        mb_c = w_q;
      end
      default: ;
    endcase
    mul_c = ma_c * mb_c;
  end

  assign rb_c    = sr_q + sb_q;
  assign trial_c = {rem_q, num_q[DivW-1]};

  always_comb begin
    proj_c = ProjW'(prod_q >>> UFrac);
    v_c    = VW'(n_q[cmd_i.lane]) - VW'(proj_c);
    av_c   = v_c[VW-1] ? VW'(-v_c) : VW'(v_c);
    rsh_c  = (ShW+1)'(62) - (ShW+1)'(e_q);
    ovf_c  = (av_c != '0) && ((av_c >> rsh_c) != '0);
    nsh_c  = (DivW+VW)'(av_q) << e_q;
  end

  always_comb begin
    al_c   = cmd_i.lane + 2'd1;
    qv_c   = quo_q;
    qt     = ovf_q ? $signed({2'b01, {(AccW-2){1'b0}}}) : $signed(AccW'(qv_c));
    term_c = vneg_q ? qt : -qt;
    sum_c  = '0;
    if (cmd_i.op == OP_W) begin
      sum_c = add_clip(acc_q[0], t_q >>> UFrac);
    end else begin
      sum_c = add_clip(acc_q[al_c], term_c);
    end
  end

  always_comb begin
    logic signed [AccW-1:0] q;
    fin_flag_c = 1'b0;
    for (int j = 0; j < 4; j++) begin
      q = acc_q[j] >>> 2;
      if (q > $signed({{(AccW-CoordW+1){1'b0}}, {(CoordW-1){1'b1}}})) begin
        fin_c[j]   = {1'b0, {(CoordW-1){1'b1}}};
        fin_flag_c = 1'b1;
      end else if (q < $signed({{(AccW-CoordW+1){1'b1}}, {(CoordW-1){1'b0}}})) begin
        fin_c[j]   = {1'b1, {(CoordW-1){1'b0}}};
        fin_flag_c = 1'b1;
      end else begin
        fin_c[j] = q[CoordW-1:0];
      end
    end
  end

  assign stat_o.zero_dist = (m_c == '0);
  assign stat_o.overflow  = ovf_c;
  assign stat_o.last_face = ({1'b0, idx_q} == cnt_eff - CntW'(1));
  assign stat_o.cnt_zero  = (cnt_eff == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD) begin
      face_mem[face_index_i] <= face_i;
    end
    if (cmd_i.op == OP_READ) begin
      rdata_q <= face_mem[idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_START: begin
        point_q[0] <= point_x_i;
        point_q[1] <= point_y_i;
        point_q[2] <= point_z_i;
      end
      OP_DIFF: begin
        for (int i = 0; i < 3; i++) begin
          d_q[i] <= DiffW'(point_q[i]) - DiffW'($signed(rdata_q[(5-i)*CoordW +: CoordW]));
          n_q[i] <= $signed(rdata_q[(2-i)*CoordW +: CoordW]);
        end
      end
      OP_NORM: begin
        for (int i = 0; i < 3; i++) begin
          if (k_c > 0) begin
            a_q[i] <= NormW'(mag_c[i] >> k_c[ShW-1:0]);
          end else begin
            a_q[i] <= NormW'(mag_c[i] << ShW'(-k_c));
          end
        end
        e_q  <= ShW'((ShW+2)'(FracBits) - k_c);
        r2_q <= '0;
        t_q  <= '0;
      end
      OP_SQ, OP_TN, OP_UW: prod_q <= mul_c[ProdW-1:0];
      OP_SQACC: r2_q <= r2_q + R2W'(prod_q);
      OP_SQRT_INIT: begin
        sx_q <= SqW'(r2_q);
        sr_q <= '0;
        sb_q <= SqW'(1) << (2 * SqrtLast);
      end
      OP_SQRT_STEP: begin
        if (sx_q >= rb_c) begin
          sx_q <= sx_q - rb_c;
          sr_q <= (sr_q >> 1) + sb_q;
        end else begin
          sr_q <= sr_q >> 1;
        end
        sb_q <= sb_q >> 2;
      end
      OP_DIVU_INIT: begin
        num_q <= DivW'(a_q[cmd_i.lane]) << UFrac;
        rem_q <= '0;
      end
      OP_DIVA_INIT: begin
        num_q <= nsh_c[DivW-1:0];
        rem_q <= '0;
      end
      OP_DIV_STEP: begin
        num_q <= num_q << 1;
        if (trial_c >= {1'b0, sr_q[RnW-1:0]}) begin
          rem_q <= RnW'(trial_c - {1'b0, sr_q[RnW-1:0]});
          quo_q <= {quo_q[DivW-2:0], 1'b1};
        end else begin
          rem_q <= trial_c[RnW-1:0];
          quo_q <= {quo_q[DivW-2:0], 1'b0};
        end
      end
      OP_USTORE: begin
        u_q[cmd_i.lane] <= d_q[cmd_i.lane][DiffW-1] ? -$signed(UW'(quo_q))
                                                   : $signed(UW'(quo_q));
      end
      OP_TACC: t_q <= t_q + prod_q;
      OP_W: w_q <= WW'(t_q >>> UFrac);
      OP_V: begin
        av_q   <= av_c;
        vneg_q <= v_c[VW-1];
        ovf_q  <= ovf_c;
      end
      OP_FINISH: begin
        for (int j = 0; j < 4; j++) begin
          res_q[j] <= fin_c[j];
        end
        sat_q <= flag_q | fin_flag_c;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      face_count_q <= '0;
      idx_q        <= '0;
      flag_q       <= 1'b0;
      valid_q      <= 1'b0;
      for (int j = 0; j < 4; j++) begin
        acc_q[j] <= '0;
      end
    end else begin
      valid_q <= (cmd_i.op == OP_FINISH);
      if (cfg_we_i) begin
        face_count_q <= cfg_wdata_i;
      end
      case (cmd_i.op)
        OP_START: begin
          idx_q  <= '0;
          flag_q <= 1'b0;
          for (int j = 0; j < 4; j++) begin
            acc_q[j] <= '0;
          end
        end
        OP_W: begin
          acc_q[0] <= sum_c[AccW-1:0];
          flag_q   <= flag_q | sum_c[AccW];
        end
        OP_ACCQ: begin
          acc_q[al_c] <= sum_c[AccW-1:0];
          flag_q      <= flag_q | sum_c[AccW] | ovf_q;
        end
        OP_NEXT: idx_q <= idx_q + FaceIdxW'(1);
        default: ;
      endcase
    end
  end

  assign potential_o    = res_q[0];
  assign accel_x_o      = res_q[1];
  assign accel_y_o      = res_q[2];
  assign accel_z_o      = res_q[3];
  assign saturated_o    = sat_q;
  assign result_valid_o = valid_q;

endmodule
